>>> hdl/aaic_pkg.sv
package aaic_pkg;

  localparam int MAC_W  = 48;
  localparam int ID_W   = 64;
  localparam int LEN_W  = 4;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd10000;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_DELETED   = 3'd6,
    ST_NOT_FOUND = 3'd7
  } status_t;

  typedef enum logic {
    CMT_WRITE = 1'b0,
    CMT_CLEAR = 1'b1
  } cmt_kind_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [MAC_W-1:0]  mac_address;
    logic [ID_W-1:0]   node_id;
    logic [LEN_W-1:0]  id_length;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   found_id;
    logic [LEN_W-1:0]  found_length;
  } rsp_t;

  // Scan token and running result passed from cell to cell.
  typedef struct packed {
    logic              tok;
    logic              found;
    logic              free_seen;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] stamp;
  } link_t;

  // Commit command broadcast to all cells.
  typedef struct packed {
    logic              en;
    cmt_kind_t         kind;
    logic              use_hit;
    logic [MAC_W-1:0]  mac;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] stamp;
  } commit_t;

  function automatic logic [ID_W-1:0] byte_mask(logic [LEN_W-1:0] n);
    logic [5:0] sh;
    sh = {n[2:0], 3'b000};
    if (n >= 4'd8) begin
      return '1;
    end
    return (64'd1 << sh) - 64'd1;
  endfunction

endpackage

>>> hdl/aaic_cell.sv
module aaic_cell #(
  parameter int ID_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [aaic_pkg::MAC_W-1:0]     probe_mac,
  input  aaic_pkg::link_t                link_in,
  output aaic_pkg::link_t                link_out,
  input  aaic_pkg::commit_t              cmd
);
  import aaic_pkg::*;

  localparam int SLOT_ID_W = 8 * ID_BYTES;

  logic                  slot_valid;
  logic [MAC_W-1:0]      slot_mac;
  logic [SLOT_ID_W-1:0]  slot_id;
  logic [LEN_W-1:0]      slot_len;
  logic [TIME_W-1:0]     slot_stamp;
  logic                  sel_hit;
  logic                  sel_free;
  logic                  match;
  logic                  first_hit;
  logic                  chosen;

  assign match     = slot_valid && (slot_mac == probe_mac);
  assign first_hit = match && !link_in.found;
  assign chosen    = cmd.en && (cmd.use_hit ? sel_hit : sel_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      sel_hit    <= 1'b0;
      sel_free   <= 1'b0;
      link_out   <= '0;
    end else begin
      link_out.tok       <= link_in.tok;
      link_out.found     <= link_in.found | match;
      link_out.free_seen <= link_in.free_seen | !slot_valid;
      if (first_hit) begin
        link_out.id    <= ID_W'(slot_id);
        link_out.len   <= slot_len;
        link_out.stamp <= slot_stamp;
      end else begin
        link_out.id    <= link_in.id;
        link_out.len   <= link_in.len;
        link_out.stamp <= link_in.stamp;
      end
      // Latch this cell's role while the token passes.
      if (link_in.tok) begin
        sel_hit  <= first_hit;
        sel_free <= !slot_valid && !link_in.free_seen;
      end
      if (chosen) begin
        slot_valid <= (cmd.kind == CMT_WRITE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chosen && cmd.kind == CMT_WRITE) begin
      slot_mac   <= cmd.mac;
      slot_id    <= cmd.id[SLOT_ID_W-1:0];
      slot_len   <= cmd.len;
      slot_stamp <= cmd.stamp;
    end
  end

endmodule

>>> hdl/aging_address_id_cache.sv
// Associative table of ENTRIES slots mapping 48-bit MAC addresses to node
// identifiers of up to ID_BYTES bytes, each stamped with the time of its last
// write. Requests (add/update, lookup, delete) carry the current time; a
// lookup hits only while (now_ms - stamp) mod 2^32 is below max_age_ms, and
// an older entry is dropped and reported as expired. Add saturates the length
// to ID_BYTES and zeroes identifier bytes beyond it; with no match and no free
// slot it reports full. The table is a row of cells, one per slot. A scan
// token walks the row one cell per cycle, each cell comparing its address and
// handing the first match and first-free flags to its neighbor; the decision
// is then registered, and a one-cycle commit writes or clears the chosen cell.
// One transaction is in work at a time: the next request is accepted at the
// earliest in the cycle the result appears, so no new request is taken
// before the current one has finished. The result waits in an output
// register; a stalled result holds the commit and the next request. Valid
// bits clear at reset; max_age_ms resets to 10000 and the configuration port
// is always ready.
module aging_address_id_cache #(
  parameter int ENTRIES  = 16,
  parameter int ID_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aaic_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output aaic_pkg::rsp_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aaic_pkg::TIME_W-1:0]   cfg_data
);
  import aaic_pkg::*;

  localparam logic [LEN_W-1:0] ID_LEN_MAX = LEN_W'(ID_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  logic                start_q;
  logic [TIME_W-1:0]   max_age;

  // Request held for the whole transaction.
  logic [1:0]          req_action;
  logic [MAC_W-1:0]    req_mac;
  logic [ID_W-1:0]     req_id;
  logic [LEN_W-1:0]    req_len;
  logic [TIME_W-1:0]   req_now;

  // Decision taken at the end of the scan.
  rsp_t                res;
  logic                cmt_en;
  cmt_kind_t           cmt_kind;
  logic                cmt_use_hit;
  rsp_t                res_next;
  logic                cmt_en_next;
  cmt_kind_t           cmt_kind_next;

  link_t               links [ENTRIES+1];
  logic [ENTRIES-1:0]  tok_vec;
  commit_t             cmd;
  link_t               last;
  logic                in_take;
  logic                out_free;
  logic [LEN_W-1:0]    len_sat;
  logic [TIME_W-1:0]   age;
  logic                fresh;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign len_sat = (in_data.id_length > ID_LEN_MAX) ? ID_LEN_MAX : in_data.id_length;

  // Inject the token at the head of the row.
  assign links[0] = '{tok: start_q, found: 1'b0, free_seen: 1'b0,
                      id: '0, len: '0, stamp: '0};
  assign last  = links[ENTRIES];
  assign age   = req_now - last.stamp;
  assign fresh = (age < max_age);

  assign cmd = '{en: (state == S_FINISH) && out_free && cmt_en, kind: cmt_kind,
                 use_hit: cmt_use_hit, mac: req_mac, id: req_id, len: req_len,
                 stamp: req_now};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    aaic_cell #(
      .ID_BYTES(ID_BYTES)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_mac(req_mac),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .cmd      (cmd)
    );
    assign tok_vec[i] = links[i+1].tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MAX_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_age <= cfg_data;
    end
  end

  // Latch the request with the length saturated and the identifier masked.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_action <= in_data.action;
      req_mac    <= in_data.mac_address;
      req_id     <= in_data.node_id & byte_mask(len_sat);
      req_len    <= len_sat;
      req_now    <= in_data.now_ms;
    end
  end

  // Work out the response and the commit from what the token gathered.
  always_comb begin
    res_next      = '{status: ST_NOT_FOUND, found_id: '0, found_length: '0};
    cmt_en_next   = 1'b0;
    cmt_kind_next = CMT_WRITE;
    case (req_action)
      ACT_ADD: begin
        if (last.found || last.free_seen) begin
          cmt_en_next = 1'b1;
          res_next    = '{status: last.found ? ST_UPDATED : ST_INSERTED,
                          found_id: req_id, found_length: req_len};
        end else begin
          res_next.status = ST_FULL;
        end
      end
      ACT_LOOKUP: begin
        if (!last.found) begin
          res_next.status = ST_MISS;
        end else if (fresh) begin
          res_next = '{status: ST_HIT, found_id: last.id, found_length: last.len};
        end else begin
          // Drop the stale entry.
          cmt_en_next     = 1'b1;
          cmt_kind_next   = CMT_CLEAR;
          res_next.status = ST_EXPIRED;
        end
      end
      ACT_DELETE: begin
        if (last.found) begin
          cmt_en_next     = 1'b1;
          cmt_kind_next   = CMT_CLEAR;
          res_next.status = ST_DELETED;
        end
      end
      default: begin
        res_next.status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_q     <= 1'b0;
      out_valid   <= 1'b0;
      cmt_en      <= 1'b0;
      cmt_kind    <= CMT_WRITE;
      cmt_use_hit <= 1'b0;
    end else begin
      start_q <= in_take;
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last.tok) begin
            state       <= S_FINISH;
            cmt_en      <= cmt_en_next;
            cmt_kind    <= cmt_kind_next;
            cmt_use_hit <= last.found;
            res         <= res_next;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free, then commit and report.
          if (out_free) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // At most one scan token in flight.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({start_q, tok_vec}))
    else $error("more than one scan token in the cell row");

  // Tokens travel only during a scan.
  a_tok_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((|tok_vec) || start_q) |-> (state == S_SCAN))
    else $error("scan token outside of scan state");

  // An accepted request launches a token.
  a_launch: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (start_q && state == S_SCAN))
    else $error("accepted transaction did not start a scan");

  // A result appears only out of the finish step.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result presented outside of finish step");

endmodule
